/* design/gvs_pkg.sv */
// gvs_pkg: shared constants, controller states and command/status structs
// for the grey value statistics block; no dependencies
package gvs_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int COUNT_BITS = 24;

    localparam int DIV_STEPS  = 110;
    localparam int MUL_STEPS  = 40;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_BITS  = 7;

    localparam logic signed [31:0] MEAN_EMPTY = -32'sd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_LD,
        ST_MEAN_RUN,
        ST_MUL_A_LD,
        ST_MUL_A_RUN,
        ST_MUL_B_LD,
        ST_MUL_B_RUN,
        ST_VAR_LD,
        ST_VAR_RUN,
        ST_SQRT_LD,
        ST_SQRT_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic acc_en;
        logic snap;
        logic div_load_mean;
        logic div_load_var;
        logic div_step;
        logic mean_cap;
        logic mul_load_a;
        logic mul_load_b;
        logic mul_step;
        logic sqrt_load;
        logic sqrt_step;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_stat;

endpackage

/* design/gvs_ctrl.sv */
// gvs_ctrl: sequencer for accumulate and report phases
// depends on gvs_pkg
module gvs_ctrl
    import gvs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_cmd,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step + 1'b1;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.acc_en = i_in_valid & ~i_in_cmd;
                o_cmd.snap   = i_in_valid & i_in_cmd;
                if (i_in_valid && i_in_cmd) begin
                    n_state = ST_MEAN_LD;
                end
            end
            ST_MEAN_LD: begin
                o_cmd.div_load_mean = 1'b1;
                n_step  = '0;
                n_state = ST_MEAN_RUN;
            end
            ST_MEAN_RUN: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_BITS'(DIV_STEPS - 1)) begin
                    n_state = ST_MUL_A_LD;
                end
            end
            ST_MUL_A_LD: begin
                o_cmd.mean_cap   = 1'b1;
                o_cmd.mul_load_a = 1'b1;
                n_step  = '0;
                n_state = ST_MUL_A_RUN;
            end
            ST_MUL_A_RUN: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == STEP_BITS'(MUL_STEPS - 1)) begin
                    n_state = ST_MUL_B_LD;
                end
            end
            ST_MUL_B_LD: begin
                o_cmd.mul_load_b = 1'b1;
                n_step  = '0;
                n_state = ST_MUL_B_RUN;
            end
            ST_MUL_B_RUN: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == STEP_BITS'(MUL_STEPS - 1)) begin
                    n_state = ST_VAR_LD;
                end
            end
            ST_VAR_LD: begin
                o_cmd.div_load_var = 1'b1;
                n_step  = '0;
                n_state = ST_VAR_RUN;
            end
            ST_VAR_RUN: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_BITS'(DIV_STEPS - 1)) begin
                    n_state = ST_SQRT_LD;
                end
            end
            ST_SQRT_LD: begin
                o_cmd.sqrt_load = 1'b1;
                n_step  = '0;
                n_state = ST_SQRT_RUN;
            end
            ST_SQRT_RUN: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == STEP_BITS'(SQRT_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.res_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> !i_stat.out_full)
        else $error("result loaded over a pending result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.snap |=> r_state == ST_MEAN_LD)
        else $error("report request did not start the sequence");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT_RUN && r_step == STEP_BITS'(SQRT_STEPS - 1)) |=> r_state == ST_DONE)
        else $error("root did not finish after its step count");

endmodule

/* design/gvs_dp.sv */
// gvs_dp: accumulators, serial multiplier, shared divider, square root
// and result register; depends on gvs_pkg
module gvs_dp
    import gvs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    input  logic [15:0]   i_pixel,
    input  logic          i_out_take,
    output t_dp_stat      o_stat,
    output logic [215:0]  o_data,
    output logic          o_ovf
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] r_cnt;
    logic signed [15:0]    r_min, r_max;
    logic signed [39:0]    r_sum;
    logic [53:0]           r_sq;
    logic                  r_ovf;

    logic [COUNT_BITS-1:0] r_s_cnt;
    logic signed [15:0]    r_s_min, r_s_max;
    logic signed [39:0]    r_s_sum;
    logic [53:0]           r_s_sq;
    logic                  r_s_ovf;

    logic [47:0]  r_den;
    logic [31:0]  r_mean;
    logic [79:0]  r_p, r_m;
    logic [39:0]  r_q;
    logic         r_mul_sub;
    logic [48:0]  r_rem;
    logic [109:0] r_dvd;
    logic [63:0]  r_quo;
    logic [47:0]  r_dvs;
    logic [63:0]  r_x;
    logic [34:0]  r_srem;
    logic [31:0]  r_root;

    logic         r_out_full;
    logic [23:0]  r_o_cnt;
    logic [15:0]  r_o_min, r_o_max;
    logic [39:0]  r_o_sum;
    logic [53:0]  r_o_sq;
    logic [31:0]  r_o_mean, r_o_std;
    logic         r_o_ovf;

    logic signed [15:0] pix_v;
    logic signed [31:0] pix_sq;
    logic [39:0]        sum_mag;
    logic [48:0]        rem_sh;
    logic [34:0]        srem_sh;
    logic [34:0]        trial;

    assign pix_v   = 16'($signed(i_pixel[PIXEL_BITS-1:0]));
    assign pix_sq  = pix_v * pix_v;
    assign sum_mag = r_s_sum[39] ? 40'(-r_s_sum) : 40'(r_s_sum);
    assign rem_sh  = {r_rem[47:0], r_dvd[109]};
    assign srem_sh = {r_srem[32:0], r_x[63:62]};
    assign trial   = {1'b0, r_root, 2'b01};

    // running accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_min <= '0;
            r_max <= '0;
            r_sum <= '0;
            r_sq  <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.snap) begin
            r_cnt <= '0;
            r_min <= '0;
            r_max <= '0;
            r_sum <= '0;
            r_sq  <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.acc_en) begin
            if (r_cnt == COUNT_MAX) begin
                r_ovf <= 1'b1;
            end else begin
                if (r_cnt == '0 || pix_v < r_min) begin
                    r_min <= pix_v;
                end
                if (r_cnt == '0 || pix_v > r_max) begin
                    r_max <= pix_v;
                end
                r_sum <= r_sum + 40'(pix_v);
                r_sq  <= r_sq + 54'(unsigned'(pix_sq));
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // report datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            r_s_cnt <= r_cnt;
            r_s_min <= r_min;
            r_s_max <= r_max;
            r_s_sum <= r_sum;
            r_s_sq  <= r_sq;
            r_s_ovf <= r_ovf;
        end
        if (i_cmd.div_load_mean) begin
            r_rem <= '0;
            r_quo <= '0;
            r_dvs <= 48'(r_s_cnt);
            r_dvd <= 110'({sum_mag, 16'd0});
        end else if (i_cmd.div_load_var) begin
            r_rem <= '0;
            r_quo <= '0;
            r_dvs <= r_den;
            r_dvd <= {r_p[77:0], 32'd0};
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[108:0], 1'b0};
            if (rem_sh >= {1'b0, r_dvs}) begin
                r_rem <= rem_sh - {1'b0, r_dvs};
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
        if (i_cmd.mean_cap) begin
            if (r_s_cnt == '0) begin
                r_mean <= MEAN_EMPTY;
            end else if (r_s_sum[39]) begin
                r_mean <= 32'(-r_quo[31:0]);
            end else begin
                r_mean <= r_quo[31:0];
            end
            r_den <= 48'(r_s_cnt) * 48'(r_s_cnt - 1'b1);
        end
        if (i_cmd.mul_load_a) begin
            r_p       <= '0;
            r_m       <= 80'(r_s_sq);
            r_q       <= 40'(r_s_cnt);
            r_mul_sub <= 1'b0;
        end else if (i_cmd.mul_load_b) begin
            r_m       <= 80'(sum_mag);
            r_q       <= sum_mag;
            r_mul_sub <= 1'b1;
        end else if (i_cmd.mul_step) begin
            if (r_q[0]) begin
                r_p <= r_mul_sub ? r_p - r_m : r_p + r_m;
            end
            r_m <= {r_m[78:0], 1'b0};
            r_q <= {1'b0, r_q[39:1]};
        end
        if (i_cmd.sqrt_load) begin
            r_x    <= r_quo;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_x <= {r_x[61:0], 2'b00};
            if (srem_sh >= trial) begin
                r_srem <= srem_sh - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_srem <= srem_sh;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_full <= 1'b1;
        end else if (i_out_take) begin
            r_out_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_o_cnt  <= 24'(r_s_cnt);
            r_o_min  <= r_s_min;
            r_o_max  <= r_s_max;
            r_o_sum  <= r_s_sum;
            r_o_sq   <= r_s_sq;
            r_o_mean <= r_mean;
            r_o_std  <= (r_s_cnt < COUNT_BITS'(2)) ? 32'd0 : r_root;
            r_o_ovf  <= r_s_ovf;
        end
    end

    assign o_stat.out_full = r_out_full;
    assign o_data = {2'b00, r_o_std, r_o_mean, r_o_sq, r_o_sum, r_o_max, r_o_min, r_o_cnt};
    assign o_ovf  = r_o_ovf;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.snap |=> (r_cnt == '0 && r_sum == '0 && r_sq == '0 && !r_ovf))
        else $error("accumulators not cleared after report");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc_en && !i_cmd.snap && r_cnt != COUNT_MAX) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("pixel count did not advance");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_min <= r_max))
        else $error("minimum above maximum");

endmodule

/* design/grey_value_statistics.sv */
// grey_value_statistics: top level, count/min/max/sum/sum of squares, mean and
// sample standard deviation of a grey value stream; uses gvs_pkg, gvs_ctrl, gvs_dp
//
// channel   dir  fields
// s_axis    in   tuser: cmd; tdata: pixel_value
// m_axis    out  tdata: count, min, max, sum, square sum, mean, stddev; tuser: overflow
//
// a pixel request is taken every cycle while idle; after its accept a report runs
// the divider for the mean, two multiplier passes, the divider for the variance,
// the square root and a done state; input is held off meanwhile
// the result waits in an output register; pixels keep flowing while it waits,
// a second report stalls in its done cycle until the register empties
// synchronous active low reset clears accumulators and control
module grey_value_statistics
    import gvs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,  // [15:0] pixel_value
    input  logic         s_axis_tuser,  // [0] cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [23:0] pixel_count, [39:24] min_value, [55:40] max_value, [95:56] value_sum,
    // [149:96] square_sum, [181:150] mean_q16, [213:182] stddev_q16, [215:214] zero
    output logic [215:0] m_axis_tdata,
    output logic         m_axis_tuser   // [0] count_overflow
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    gvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    gvs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_pixel    (s_axis_tdata),
        .i_out_take (m_axis_tvalid & m_axis_tready),
        .o_stat     (stat),
        .o_data     (m_axis_tdata),
        .o_ovf      (m_axis_tuser)
    );

    assign m_axis_tvalid = stat.out_full;

endmodule

/* sim/grey_value_statistics_checker.sv */
// grey_value_statistics_checker: watches both stream channels of the grey value
// statistics block, predicts each report and compares it field by field; uses gvs_pkg
module grey_value_statistics_checker
    import gvs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [15:0]  i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [215:0] i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [23:0]        count;
        logic signed [15:0] min_v;
        logic signed [15:0] max_v;
        logic signed [39:0] sum;
        logic [53:0]        sq;
        logic signed [31:0] mean;
        logic [31:0]        stddev;
        logic               ovf;
    } t_stats;

    localparam logic [23:0] COUNT_FULL = {COUNT_BITS{1'b1}};

    logic [23:0]        count_acc;
    logic signed [15:0] min_acc;
    logic signed [15:0] max_acc;
    longint             sum_acc;
    logic [63:0]        square_acc;
    logic               ovf_acc;
    t_stats             expected_reports[$];

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_stats summarize();
        t_stats s;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] q;
        longint mag;
        longint m;
        s.count = count_acc;
        s.min_v = min_acc;
        s.max_v = max_acc;
        s.sum = sum_acc[39:0];
        s.sq = square_acc[53:0];
        s.ovf = ovf_acc;
        m = -65536;
        if (count_acc != 0) m = (sum_acc * 65536) / longint'({40'd0, count_acc});
        s.mean = m[31:0];
        s.stddev = 0;
        if (count_acc >= 2) begin
            mag = (sum_acc < 0) ? -sum_acc : sum_acc;
            a = 128'(count_acc) * 128'(square_acc);
            b = 128'(mag) * 128'(mag);
            q = ((a - b) << 32) / (128'(count_acc) * 128'(count_acc - 24'd1));
            s.stddev = 32'(floor_sqrt(q[63:0]));
        end
        return s;
    endfunction

    task automatic compare_report(t_stats e, t_stats g);
        if (g.count !== e.count) begin
            $error("pixel_count: expected %0d, got %0d", e.count, g.count);
            o_fail_count++;
        end
        if (g.min_v !== e.min_v) begin
            $error("min_value: expected %0d, got %0d", e.min_v, g.min_v);
            o_fail_count++;
        end
        if (g.max_v !== e.max_v) begin
            $error("max_value: expected %0d, got %0d", e.max_v, g.max_v);
            o_fail_count++;
        end
        if (g.sum !== e.sum) begin
            $error("value_sum: expected %0d, got %0d", e.sum, g.sum);
            o_fail_count++;
        end
        if (g.sq !== e.sq) begin
            $error("square_sum: expected %0d, got %0d", e.sq, g.sq);
            o_fail_count++;
        end
        if (g.mean !== e.mean) begin
            $error("mean_q16: expected %0d, got %0d", e.mean, g.mean);
            o_fail_count++;
        end
        if (g.stddev !== e.stddev) begin
            $error("stddev_q16: expected %0d, got %0d", e.stddev, g.stddev);
            o_fail_count++;
        end
        if (g.ovf !== e.ovf) begin
            $error("count_overflow: expected %0d, got %0d", e.ovf, g.ovf);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stats got;
        logic signed [15:0] v;
        if (!i_rst_n) begin
            count_acc = 0;
            min_acc = 0;
            max_acc = 0;
            sum_acc = 0;
            square_acc = 0;
            ovf_acc = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.count = i_m_tdata[23:0];
                got.min_v = i_m_tdata[39:24];
                got.max_v = i_m_tdata[55:40];
                got.sum = i_m_tdata[95:56];
                got.sq = i_m_tdata[149:96];
                got.mean = i_m_tdata[181:150];
                got.stddev = i_m_tdata[213:182];
                got.ovf = i_m_tuser;
                if (expected_reports.size() == 0) begin
                    $error("report with none expected");
                    o_fail_count++;
                end else begin
                    compare_report(expected_reports.pop_front(), got);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser) begin
                    expected_reports.push_back(summarize());
                    count_acc = 0;
                    min_acc = 0;
                    max_acc = 0;
                    sum_acc = 0;
                    square_acc = 0;
                    ovf_acc = 0;
                end else if (count_acc == COUNT_FULL) begin
                    ovf_acc = 1;
                end else begin
                    v = i_s_tdata;
                    if (count_acc == 0 || v < min_acc) min_acc = v;
                    if (count_acc == 0 || v > max_acc) max_acc = v;
                    sum_acc += longint'(v);
                    square_acc += 64'(longint'(v) * longint'(v));
                    count_acc++;
                end
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

/* sim/grey_value_statistics_tb.sv */
// grey_value_statistics_tb: stimulus, stall patterns and verdict for the grey value
// statistics block; uses grey_value_statistics and grey_value_statistics_checker
module grey_value_statistics_tb;

    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_CYCLES = 1500;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = 0;  // [15:0] pixel_value
    logic         s_axis_tuser = 0;  // [0] cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [215:0] m_axis_tdata;      // count, min, max, sum, square sum, mean, stddev
    logic         m_axis_tuser;      // [0] count_overflow
    int           fail_count;
    int           pending;
    int           burst_left = 0;
    int           idle_cycles = 0;
    bit           hold_request = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    grey_value_statistics i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    grey_value_statistics_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 0;
        end else begin
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: m_axis_tready <= 1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(logic cmd, logic [15:0] value);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= value;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int n;
        int sent;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // empty set, single pixel, extremes, repeated reports
        send_request(1, 16'h1234);
        send_request(0, 16'h8000);
        send_request(1, 16'hffff);
        send_request(0, 16'h7fff);
        send_request(1, 16'h0000);
        send_request(0, 16'h7fff);
        send_request(0, 16'h8000);
        send_request(0, 16'h0000);
        send_request(0, 16'hffff);
        send_request(1, 16'h5555);
        send_request(0, 16'h0005);
        send_request(0, 16'h0005);
        send_request(1, 16'haaaa);
        repeat (6) send_request(0, 16'h8000);
        send_request(1, 16'h0000);
        send_request(1, 16'h0000);

        sent = 0;
        while (sent < 750) begin
            if (sent > 150 && !hold_request) begin
                // reports pile up behind the stalled output
                hold_request = 1;
                repeat (3) begin
                    send_request(0, random_pixel());
                    send_request(1, 16'($urandom));
                end
                sent += 6;
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 25);
            repeat (n) send_request(0, random_pixel());
            send_request(1, 16'($urandom));
            sent += n + 1;
        end
        s_axis_tvalid <= 0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* grey_value_statistics.f */
design/gvs_pkg.sv
design/gvs_ctrl.sv
design/gvs_dp.sv
design/grey_value_statistics.sv
sim/grey_value_statistics_checker.sv
sim/grey_value_statistics_tb.sv
